/* hdl/pfp_pkg.sv */
package pfp_pkg;

  // Frame limits and number format
  localparam int MAX_LINES = 32;
  localparam int FRAC_BITS = 16;

  localparam int COORD_W = 16;                  // coordinate and frame size width
  localparam int HALF_W  = COORD_W - 1;         // half of a 16-bit size
  localparam int NUM_W   = COORD_W + FRAC_BITS; // dividend magnitude width
  localparam int SAT_W   = (NUM_W > 33) ? NUM_W : 33;
  localparam int DCNT_W  = $clog2(NUM_W + 1);
  localparam int BYTE_W  = 8;
  localparam int LINE_W  = $clog2(MAX_LINES + 1);
  localparam int IDX_W   = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int BPOS_W  = 3;

  localparam logic [COORD_W-1:0] RESTART_INDEX = '1;

  typedef enum logic [1:0] {
    KIND_POINT   = 2'd0,
    KIND_RESTART = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_TRUNC = 2'd1,
    ERR_LINES = 2'd2,
    ERR_HALF  = 2'd3
  } err_t;

  typedef struct packed {
    kind_t               kind;
    logic [COORD_W-1:0]  point_index;
    logic signed [31:0]  x_norm;
    logic signed [31:0]  y_norm;
    logic                saturated;
    err_t                error_code;
    logic                last;
  } res_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] value;
  } div_res_t;

endpackage

/* hdl/pfp_divider.sv */
module pfp_divider import pfp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [COORD_W-1:0] v,
  input  logic [HALF_W-1:0]  half,
  output logic               done,
  output div_res_t           res
);

  logic              run;
  logic [DCNT_W-1:0] cnt;
  logic [HALF_W-1:0] rem;
  logic [HALF_W-1:0] dsr;
  logic [NUM_W-1:0]  quo;
  logic              neg;

  logic signed [COORD_W:0] diff;
  logic [COORD_W-1:0]      mag;
  logic [HALF_W:0]         trial;
  logic                    ge;
  logic [SAT_W-1:0]        qe;
  logic                    sat_pos;
  logic                    sat_neg;

  assign diff  = $signed({1'b0, v}) - $signed({2'b00, half});
  assign mag   = diff[COORD_W] ? (~diff[COORD_W-1:0] + COORD_W'(1)) : diff[COORD_W-1:0];
  assign trial = {rem, quo[NUM_W-1]};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && run && (cnt == DCNT_W'(1));
      if (start) begin
        run <= 1'b1;
        cnt <= DCNT_W'(NUM_W);
      end else if (run) begin
        cnt <= cnt - DCNT_W'(1);
        if (cnt == DCNT_W'(1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  // One restoring step per cycle; the dividend shifts out as the quotient shifts in
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= {mag, {FRAC_BITS{1'b0}}};
      rem <= '0;
      dsr <= half;
      neg <= diff[COORD_W];
    end else if (run) begin
      quo <= {quo[NUM_W-2:0], ge};
      rem <= ge ? HALF_W'(trial - {1'b0, dsr}) : trial[HALF_W-1:0];
    end
  end

  // Apply sign and clip to the signed 32-bit range
  assign qe      = SAT_W'(quo);
  assign sat_pos = qe > SAT_W'(32'h7FFF_FFFF);
  assign sat_neg = qe > SAT_W'(32'h8000_0000);

  always_comb begin
    if (neg) begin
      res.sat   = sat_neg;
      res.value = sat_neg ? 32'sh8000_0000 : $signed(~qe[31:0] + 32'd1);
    end else begin
      res.sat   = sat_pos;
      res.value = sat_pos ? 32'sh7FFF_FFFF : $signed(qe[31:0]);
    end
  end

endmodule

/* hdl/pfp_seq.sv */
module pfp_seq import pfp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [BYTE_W-1:0]  data_byte,
  input  logic               end_of_frame,
  output logic               in_stall,
  input  logic               push_ok,
  output logic               push,
  output res_t               push_res,
  output logic               div_start,
  output logic [COORD_W-1:0] div_v,
  output logic [HALF_W-1:0]  div_half,
  input  logic               div_done,
  input  div_res_t           div_res
);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_PARSE   = 11'b000_0000_0010,
    S_LINE    = 11'b000_0000_0100,
    S_DIVX    = 11'b000_0000_1000,
    S_WAITX   = 11'b000_0001_0000,
    S_WAITY   = 11'b000_0010_0000,
    S_POINT   = 11'b000_0100_0000,
    S_RESTART = 11'b000_1000_0000,
    S_TAIL    = 11'b001_0000_0000,
    S_FINISH  = 11'b010_0000_0000,
    S_FETCH   = 11'b100_0000_0000
  } seq_t;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_COUNTS = 5'b00010,
    PH_POINTS = 5'b00100,
    PH_DONE   = 5'b01000,
    PH_SKIP   = 5'b10000
  } phase_t;

  seq_t               state;
  phase_t             phase;
  logic [BPOS_W-1:0]  bpos;
  logic [COORD_W-1:0] frame_width;
  logic [COORD_W-1:0] frame_height;
  logic [BYTE_W-1:0]  line_total;
  logic [BYTE_W-1:0]  counts [MAX_LINES];
  logic [LINE_W-1:0]  cursor;
  logic [BYTE_W-1:0]  points_left;
  logic [COORD_W-1:0] point_counter;
  logic [23:0]        coord_hold;
  logic               pend_valid;

  logic [BYTE_W-1:0]  byte_reg;
  logic               eof_reg;
  logic [COORD_W-1:0] x_reg;
  logic [COORD_W-1:0] y_reg;
  logic signed [31:0] xn;
  logic signed [31:0] yn;
  logic               sat_x;
  logic               sat_y;
  res_t               pend;

  logic [HALF_W-1:0]  hw;
  logic [HALF_W-1:0]  hh;
  logic               half_zero;
  logic [LINE_W-1:0]  cursor_inc;
  logic               line_end;
  logic [BYTE_W-1:0]  cnt_cur;
  logic               count_we;
  logic               gen;
  res_t               gen_res;
  logic               go;

  assign hw         = frame_width[COORD_W-1:1];
  assign hh         = frame_height[COORD_W-1:1];
  assign half_zero  = (hw == '0) || (hh == '0);
  assign cursor_inc = cursor + LINE_W'(1);
  assign line_end   = (BYTE_W'(cursor) >= line_total) || (cursor >= LINE_W'(MAX_LINES));
  assign in_stall   = (state != S_IDLE);

  assign count_we = (state == S_PARSE) && (phase == PH_COUNTS) &&
                    (cursor < LINE_W'(MAX_LINES));

  // Count store: write while parsing counts, read into cnt_cur in the fetch state ahead of the line check
  always_ff @(posedge clk) begin
    if (count_we) begin
      counts[cursor[IDX_W-1:0]] <= byte_reg;
    end
    if (state == S_FETCH) begin
      cnt_cur <= counts[cursor[IDX_W-1:0]];
    end
  end

  // Result generation for the current step
  always_comb begin
    gen                 = 1'b0;
    gen_res             = '0;
    gen_res.kind        = KIND_ERROR;
    gen_res.error_code  = ERR_NONE;
    case (state)
      S_PARSE: begin
        if (phase == PH_HEADER && bpos == BPOS_W'(4) && byte_reg > BYTE_W'(MAX_LINES)) begin
          gen                = 1'b1;
          gen_res.error_code = ERR_LINES;
        end
        if (phase == PH_POINTS && bpos == BPOS_W'(3) && half_zero) begin
          gen                = 1'b1;
          gen_res.error_code = ERR_HALF;
        end
      end
      S_LINE: begin
        if (!line_end && cnt_cur == '0) begin
          gen                 = 1'b1;
          gen_res.kind        = KIND_RESTART;
          gen_res.point_index = RESTART_INDEX;
        end
      end
      S_RESTART: begin
        gen                 = 1'b1;
        gen_res.kind        = KIND_RESTART;
        gen_res.point_index = RESTART_INDEX;
      end
      S_POINT: begin
        gen                 = 1'b1;
        gen_res.kind        = KIND_POINT;
        gen_res.point_index = point_counter;
        gen_res.x_norm      = xn;
        gen_res.y_norm      = yn;
        gen_res.saturated   = sat_x | sat_y;
      end
      S_TAIL: begin
        if (eof_reg && (phase inside {PH_HEADER, PH_COUNTS, PH_POINTS})) begin
          gen                = 1'b1;
          gen_res.error_code = ERR_TRUNC;
        end
      end
      default: begin
        gen = 1'b0;
      end
    endcase
  end

  // A new result displaces the held one; hold everything if it cannot leave
  assign go = !gen || !pend_valid || push_ok;

  always_comb begin
    push          = pend_valid && push_ok && ((gen && go) || (state == S_FINISH));
    push_res      = pend;
    push_res.last = (state == S_FINISH);
  end

  assign div_start = (state == S_DIVX) || (state == S_WAITX && div_done);
  assign div_v     = (state == S_DIVX) ? x_reg : y_reg;
  assign div_half  = (state == S_DIVX) ? hw : hh;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      phase         <= PH_HEADER;
      bpos          <= '0;
      frame_width   <= '0;
      frame_height  <= '0;
      line_total    <= '0;
      cursor        <= '0;
      points_left   <= '0;
      point_counter <= '0;
      coord_hold    <= '0;
      pend_valid    <= 1'b0;
    end else begin
      if (gen && go) begin
        pend_valid <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_PARSE;
          end
        end
        S_PARSE: begin
          if (go) begin
            case (phase)
              PH_HEADER: begin
                state <= S_TAIL;
                bpos  <= bpos + BPOS_W'(1);
                case (bpos)
                  BPOS_W'(0): frame_width  <= {byte_reg, 8'h00};
                  BPOS_W'(1): frame_width  <= {frame_width[15:8], byte_reg};
                  BPOS_W'(2): frame_height <= {byte_reg, 8'h00};
                  BPOS_W'(3): frame_height <= {frame_height[15:8], byte_reg};
                  default: begin
                    line_total <= byte_reg;
                    cursor     <= '0;
                    if (byte_reg > BYTE_W'(MAX_LINES)) begin
                      phase <= PH_SKIP;
                    end else if (byte_reg == '0) begin
                      phase <= PH_DONE;
                    end else begin
                      phase <= PH_COUNTS;
                    end
                  end
                endcase
              end
              PH_COUNTS: begin
                if (BYTE_W'(cursor_inc) >= line_total) begin
                  cursor        <= '0;
                  point_counter <= '0;
                  phase         <= PH_POINTS;
                  state         <= S_FETCH;
                end else begin
                  cursor <= cursor_inc;
                  state  <= S_TAIL;
                end
              end
              PH_POINTS: begin
                case (bpos)
                  BPOS_W'(0): begin
                    coord_hold <= {16'h0000, byte_reg};
                    bpos       <= bpos + BPOS_W'(1);
                    state      <= S_TAIL;
                  end
                  BPOS_W'(1), BPOS_W'(2): begin
                    coord_hold <= {coord_hold[15:0], byte_reg};
                    bpos       <= bpos + BPOS_W'(1);
                    state      <= S_TAIL;
                  end
                  default: begin
                    bpos <= '0;
                    if (half_zero) begin
                      phase <= PH_SKIP;
                      state <= S_TAIL;
                    end else begin
                      state <= S_DIVX;
                    end
                  end
                endcase
              end
              default: begin
                state <= S_TAIL;
              end
            endcase
          end
        end
        S_FETCH: begin
          state <= S_LINE;
        end
        S_LINE: begin
          if (go) begin
            if (line_end) begin
              phase <= PH_DONE;
              state <= S_TAIL;
            end else if (cnt_cur == '0) begin
              cursor <= cursor_inc;
              state  <= S_FETCH;
            end else begin
              points_left <= cnt_cur;
              bpos        <= '0;
              state       <= S_TAIL;
            end
          end
        end
        S_DIVX: begin
          state <= S_WAITX;
        end
        S_WAITX: begin
          if (div_done) begin
            state <= S_WAITY;
          end
        end
        S_WAITY: begin
          if (div_done) begin
            state <= S_POINT;
          end
        end
        S_POINT: begin
          if (go) begin
            point_counter <= point_counter + COORD_W'(1);
            points_left   <= points_left - BYTE_W'(1);
            state         <= (points_left == BYTE_W'(1)) ? S_RESTART : S_TAIL;
          end
        end
        S_RESTART: begin
          if (go) begin
            cursor <= cursor_inc;
            state  <= S_FETCH;
          end
        end
        S_TAIL: begin
          if (go) begin
            if (eof_reg) begin
              phase         <= PH_HEADER;
              bpos          <= '0;
              frame_width   <= '0;
              frame_height  <= '0;
              line_total    <= '0;
              cursor        <= '0;
              points_left   <= '0;
              point_counter <= '0;
              coord_hold    <= '0;
            end
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!pend_valid || push_ok) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      byte_reg <= data_byte;
      eof_reg  <= end_of_frame;
    end
    if (state == S_PARSE && phase == PH_POINTS && bpos == BPOS_W'(3)) begin
      x_reg <= coord_hold[23:8];
      y_reg <= {coord_hold[7:0], byte_reg};
    end
    if (state == S_WAITX && div_done) begin
      xn    <= div_res.value;
      sat_x <= div_res.sat;
    end
    if (state == S_WAITY && div_done) begin
      yn    <= div_res.value;
      sat_y <= div_res.sat;
    end
    if (gen && go) begin
      pend <= gen_res;
    end
  end

endmodule

/* hdl/polyline_frame_parser_unit.sv */
// Channel  Handshake            Payload
// input    in_valid, in_stall   data_byte, end_of_frame
// output   out_valid, out_stall kind, point_index, x_norm, y_norm, saturated,
//                               error_code, last
//
// One frame byte per input transaction. A byte that completes no point passes
// through the parse, tail and finish states. The byte that ends the counts, or
// a point that ends its line, passes a fetch state and a line state for each line
// it checks (every empty line and the line where the walk stops); a point that ends
// its line also passes a restart state for its restart marker. For the fourth
// byte of a point, the x and y quotients run one after the other through a
// single radix-2 divider, one quotient bit a cycle.
// rst is synchronous and active high; it returns the parser to the header phase.
// A stalled output holds the sequencer at its next result; in_stall stays high
// until every result of the current byte has moved into the output register.
module polyline_frame_parser_unit import pfp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [BYTE_W-1:0]   data_byte,
  input  logic                end_of_frame,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          kind,
  output logic [COORD_W-1:0]  point_index,
  output logic signed [31:0]  x_norm,
  output logic signed [31:0]  y_norm,
  output logic                saturated,
  output logic [1:0]          error_code,
  output logic                last
);

  logic               push_ok;
  logic               push;
  res_t               push_res;
  res_t               out_res;
  logic               div_start;
  logic [COORD_W-1:0] div_v;
  logic [HALF_W-1:0]  div_half;
  logic               div_done;
  div_res_t           div_res;

  // Shared divider: one normalization at a time, x first and then y
  pfp_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .v     (div_v),
    .half  (div_half),
    .done  (div_done),
    .res   (div_res)
  );

  // Frame parser and result sequencer; it keeps one result in hand so that
  // the final result of a byte can be marked when the byte's work ends
  pfp_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .data_byte    (data_byte),
    .end_of_frame (end_of_frame),
    .in_stall     (in_stall),
    .push_ok      (push_ok),
    .push         (push),
    .push_res     (push_res),
    .div_start    (div_start),
    .div_v        (div_v),
    .div_half     (div_half),
    .div_done     (div_done),
    .div_res      (div_res)
  );

  // Output register: load when empty or when the current transaction leaves
  assign push_ok = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_res <= push_res;
    end
  end

  assign kind        = out_res.kind;
  assign point_index = out_res.point_index;
  assign x_norm      = out_res.x_norm;
  assign y_norm      = out_res.y_norm;
  assign saturated   = out_res.saturated;
  assign error_code  = out_res.error_code;
  assign last        = out_res.last;

endmodule

/* tb/pfp_result_checker.sv */
module pfp_result_checker import pfp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [BYTE_W-1:0]  data_byte,
  input  logic               end_of_frame,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         kind,
  input  logic [COORD_W-1:0] point_index,
  input  logic signed [31:0] x_norm,
  input  logic signed [31:0] y_norm,
  input  logic               saturated,
  input  logic [1:0]         error_code,
  input  logic               last,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    STAGE_HEADER,
    STAGE_COUNTS,
    STAGE_POINTS,
    STAGE_DONE,
    STAGE_SKIP
  } stage_t;

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  stage_t             stage;
  logic [7:0]         byte_pos;
  logic [COORD_W-1:0] frame_w;
  logic [COORD_W-1:0] frame_h;
  logic [7:0]         line_total;
  logic [7:0]         line_points [MAX_LINES];
  int                 line_cur;
  logic [7:0]         points_left;
  logic [COORD_W-1:0] point_no;
  logic [23:0]        coord_buf;
  res_t               byte_results [$];
  res_t               pending_results [$];
  int                 mismatches;

  function automatic void clear_frame_state();
    stage       = STAGE_HEADER;
    byte_pos    = '0;
    frame_w     = '0;
    frame_h     = '0;
    line_total  = '0;
    line_cur    = 0;
    points_left = '0;
    point_no    = '0;
    coord_buf   = '0;
    foreach (line_points[i]) line_points[i] = '0;
  endfunction

  function automatic void add_result(kind_t k, logic [COORD_W-1:0] idx,
                                     logic signed [31:0] xv, logic signed [31:0] yv,
                                     logic sat, err_t code);
    res_t r;
    r.kind        = k;
    r.point_index = idx;
    r.x_norm      = xv;
    r.y_norm      = yv;
    r.saturated   = sat;
    r.error_code  = code;
    r.last        = 1'b0;
    byte_results.push_back(r);
  endfunction

  // (v - half) << FRAC_BITS, divided by half toward zero, clipped to 32 bits
  function automatic logic signed [31:0] scale_coord(logic [COORD_W-1:0] v,
                                                     logic [COORD_W-1:0] half,
                                                     inout logic sat);
    longint num;
    longint quo;
    num = longint'(v) - longint'(half);
    num = num * (longint'(1) << FRAC_BITS);
    quo = num / longint'(half);
    if (quo > Q_MAX) begin
      quo = Q_MAX;
      sat = 1'b1;
    end
    if (quo < Q_MIN) begin
      quo = Q_MIN;
      sat = 1'b1;
    end
    return quo[31:0];
  endfunction

  // Step over empty lines, one restart marker each, and load the next count.
  function automatic void walk_lines();
    while (line_cur < line_total && line_cur < MAX_LINES && line_points[line_cur] == 0) begin
      add_result(KIND_RESTART, RESTART_INDEX, '0, '0, 1'b0, ERR_NONE);
      line_cur++;
    end
    if (line_cur >= line_total || line_cur >= MAX_LINES) begin
      stage = STAGE_DONE;
    end else begin
      points_left = line_points[line_cur];
      byte_pos    = '0;
    end
  endfunction

  function automatic void close_point(logic [COORD_W-1:0] xv, logic [COORD_W-1:0] yv);
    logic [COORD_W-1:0] half_w;
    logic [COORD_W-1:0] half_h;
    logic               sat;
    logic signed [31:0] xn;
    logic signed [31:0] yn;
    half_w = frame_w >> 1;
    half_h = frame_h >> 1;
    sat    = 1'b0;
    if (half_w == 0 || half_h == 0) begin
      add_result(KIND_ERROR, '0, '0, '0, 1'b0, ERR_HALF);
      stage = STAGE_SKIP;
    end else begin
      xn = scale_coord(xv, half_w, sat);
      yn = scale_coord(yv, half_h, sat);
      add_result(KIND_POINT, point_no, xn, yn, sat, ERR_NONE);
      point_no++;
      points_left--;
      if (points_left == 0) begin
        add_result(KIND_RESTART, RESTART_INDEX, '0, '0, 1'b0, ERR_NONE);
        line_cur++;
        walk_lines();
      end
    end
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic eof);
    logic [COORD_W-1:0] xv;
    logic [COORD_W-1:0] yv;
    byte_results.delete();
    case (stage)
      STAGE_HEADER: begin
        case (byte_pos)
          8'd0: frame_w = {b, 8'h00};
          8'd1: frame_w[7:0] = b;
          8'd2: frame_h = {b, 8'h00};
          8'd3: frame_h[7:0] = b;
          default: begin
            line_total = b;
            line_cur   = 0;
            if (b > MAX_LINES) begin
              add_result(KIND_ERROR, '0, '0, '0, 1'b0, ERR_LINES);
              stage = STAGE_SKIP;
            end else if (b == 0) begin
              stage = STAGE_DONE;
            end else begin
              stage = STAGE_COUNTS;
            end
          end
        endcase
        byte_pos++;
      end
      STAGE_COUNTS: begin
        if (line_cur < MAX_LINES) line_points[line_cur] = b;
        line_cur++;
        if (line_cur >= line_total) begin
          line_cur = 0;
          point_no = '0;
          stage    = STAGE_POINTS;
          walk_lines();
        end
      end
      STAGE_POINTS: begin
        if (byte_pos == 0) coord_buf = {16'h0000, b};
        else if (byte_pos < 3) coord_buf = {coord_buf[15:0], b};
        if (byte_pos >= 3) begin
          xv       = coord_buf[23:8];
          yv       = {coord_buf[7:0], b};
          byte_pos = '0;
          close_point(xv, yv);
        end else begin
          byte_pos++;
        end
      end
      default: ;
    endcase
    if (eof) begin
      if (stage == STAGE_HEADER || stage == STAGE_COUNTS || stage == STAGE_POINTS)
        add_result(KIND_ERROR, '0, '0, '0, 1'b0, ERR_TRUNC);
      clear_frame_state();
    end
    if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last = 1'b1;
    foreach (byte_results[i]) pending_results.push_back(byte_results[i]);
  endfunction

  always @(posedge clk) begin : watch
    res_t seen;
    res_t want;
    if (rst) begin
      clear_frame_state();
      pending_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen.kind        = kind_t'(kind);
        seen.point_index = point_index;
        seen.x_norm      = x_norm;
        seen.y_norm      = y_norm;
        seen.saturated   = saturated;
        seen.error_code  = err_t'(error_code);
        seen.last        = last;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t unexpected result: kind=%0d idx=%0d x=%0d y=%0d sat=%0b err=%0d last=%0b",
                     $time, seen.kind, seen.point_index, seen.x_norm, seen.y_norm,
                     seen.saturated, seen.error_code, seen.last);
        end else begin
          want = pending_results.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t mismatch: expected kind=%0d idx=%0d x=%0d y=%0d sat=%0b err=%0d last=%0b",
                       $time, want.kind, want.point_index, want.x_norm, want.y_norm,
                       want.saturated, want.error_code, want.last);
              $display("%0t             actual kind=%0d idx=%0d x=%0d y=%0d sat=%0b err=%0d last=%0b",
                       $time, seen.kind, seen.point_index, seen.x_norm, seen.y_norm,
                       seen.saturated, seen.error_code, seen.last);
            end
          end
        end
      end
      if (in_valid && !in_stall) parse_byte(data_byte, end_of_frame);
    end
    fail_count <= mismatches;
    pending    <= pending_results.size();
  end

endmodule

/* tb/tb_top.sv */
module tb_top import pfp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Stimulus budget and run limits
  localparam int ITEMS          = 480;  // random frame bytes to send
  localparam int QUIET_TAIL     = 60;   // last bytes are sent with no idling on either side
  localparam int WATCHDOG_LIMIT = 2000; // cycles with no transaction on either channel
  localparam int DRAIN_CYCLES   = 100;  // settle time once nothing is expected

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [BYTE_W-1:0]   data_byte;
  logic                end_of_frame;
  logic                out_valid;
  logic                out_stall;
  logic [1:0]          kind;
  logic [COORD_W-1:0]  point_index;
  logic signed [31:0]  x_norm;
  logic signed [31:0]  y_norm;
  logic                saturated;
  logic [1:0]          error_code;
  logic                last;

  int                  fail_count;
  int                  pending;

  logic [7:0]          frame_q [$];  // bytes of the frame being built
  int                  random_items;
  bit                  quiet;
  int                  idle_cycles;

  polyline_frame_parser_unit uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .end_of_frame (end_of_frame),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .point_index  (point_index),
    .x_norm       (x_norm),
    .y_norm       (y_norm),
    .saturated    (saturated),
    .error_code   (error_code),
    .last         (last)
  );

  // Prediction and comparison live in the checker; this module only drives.
  pfp_result_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .end_of_frame (end_of_frame),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .point_index  (point_index),
    .x_norm       (x_norm),
    .y_norm       (y_norm),
    .saturated    (saturated),
    .error_code   (error_code),
    .last         (last),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Frame sizes: lean toward the corners. Sizes 0 and 1 give a zero half,
  // small sizes make the quotient saturate.
  function automatic logic [15:0] pick_size();
    case ($urandom_range(0, 7))
      0: return 16'($urandom_range(0, 3));
      1: return 16'hFFFF;
      2: return 16'($urandom_range(2, 64));
      default: return 16'($urandom);
    endcase
  endfunction

  // Coordinates: hit zero, full scale, the frame size, the center and its neighbor, or anything.
  function automatic logic [15:0] pick_coord(logic [15:0] size);
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return size >> 1;
      3: return size;
      4: return (size >> 1) + 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  // Append a well-formed frame: header, per-line counts, then the x,y pairs.
  function automatic void build_frame(logic [15:0] w, logic [15:0] h, int n_lines,
                                      int max_pts);
    int          total;
    int          c;
    logic [15:0] xv;
    logic [15:0] yv;
    frame_q.push_back(w[15:8]);
    frame_q.push_back(w[7:0]);
    frame_q.push_back(h[15:8]);
    frame_q.push_back(h[7:0]);
    frame_q.push_back(8'(n_lines));
    total = 0;
    repeat (n_lines) begin
      c = $urandom_range(0, max_pts);
      total += c;
      frame_q.push_back(8'(c));
    end
    repeat (total) begin
      xv = pick_coord(w);
      yv = pick_coord(h);
      frame_q.push_back(xv[15:8]);
      frame_q.push_back(xv[7:0]);
      frame_q.push_back(yv[15:8]);
      frame_q.push_back(yv[7:0]);
    end
  endfunction

  // Send one byte as one transaction. Optionally drop valid for a short burst
  // first, then hold the payload until the block takes it.
  task automatic push_byte(logic [7:0] b, logic eof);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    data_byte    <= b;
    end_of_frame <= eof;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Send the built frame; the last byte carries end_of_frame.
  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) push_byte(frame_q[i], i == frame_q.size() - 1);
    frame_q.delete();
  endtask

  // Receiver side: stall the output in bursts, none in the quiet tail.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run when neither channel moves for too long.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [15:0] w;
    logic [15:0] h;
    int          n_lines;
    int          shape;
    int          cut;
    int          n_counts;

    rst          <= 1'b1;
    in_valid     <= 1'b0;
    data_byte    <= '0;
    end_of_frame <= 1'b0;
    quiet        = 1'b0;
    random_items = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Full-scale width, height 3 (half of 1): an empty line first, then one
    // point at full scale so y saturates; end_of_frame lands on the last byte.
    frame_q = {8'hFF, 8'hFF, 8'h00, 8'h03, 8'h02, 8'h00, 8'h01,
               8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_frame();
    // One line more than the limit: too-many-lines error, nothing else.
    frame_q = {8'h00, 8'h01, 8'h00, 8'h04, 8'(MAX_LINES + 1)};
    send_frame();
    // Zero lines: the frame completes at once and yields no result.
    frame_q = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_frame();
    // Width 1 gives a zero half: the one point turns into an error.
    frame_q = {8'h00, 8'h01, 8'h00, 8'h01, 8'h01, 8'h01,
               8'h00, 8'h00, 8'h00, 8'h00};
    send_frame();
    // Header cut short: truncation error.
    frame_q = {8'h80};
    send_frame();

    // Random frames, mostly well formed with random content.
    while (random_items < ITEMS) begin
      quiet   = (random_items >= ITEMS - QUIET_TAIL);
      w       = pick_size();
      h       = pick_size();
      n_lines = ($urandom_range(0, 7) == 0) ? $urandom_range(16, MAX_LINES)
                                            : $urandom_range(0, 5);
      shape   = $urandom_range(0, 9);
      case (shape)
        6: begin
          // Truncated: drop the tail of a good frame.
          build_frame(w, h, n_lines, 3);
          cut = $urandom_range(1, frame_q.size() - 1);
          while (frame_q.size() > cut) void'(frame_q.pop_back());
        end
        7: begin
          frame_q = {w[15:8], w[7:0], h[15:8], h[7:0],
                     8'($urandom_range(MAX_LINES + 1, 255))};
        end
        8: begin
          // Large point counts, then a few bytes: almost always cut short.
          frame_q  = {w[15:8], w[7:0], h[15:8], h[7:0]};
          n_counts = $urandom_range(1, 4);
          frame_q.push_back(8'(n_counts));
          repeat (n_counts) frame_q.push_back(8'($urandom_range(0, 255)));
          repeat ($urandom_range(0, 12)) frame_q.push_back(8'($urandom));
        end
        9: begin
          repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom));
        end
        default: build_frame(w, h, n_lines, (n_lines > 8) ? 1 : 3);
      endcase
      random_items += frame_q.size();
      // Trailing bytes after a finished or rejected frame are ignored by the block.
      if ((shape <= 5 || shape == 7) && $urandom_range(0, 1) == 0)
        repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom));
      send_frame();
    end
    in_valid <= 1'b0;

    // Drain: wait for every predicted result, then let the block settle.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/pfp_pkg.sv
hdl/pfp_divider.sv
hdl/pfp_seq.sv
hdl/polyline_frame_parser_unit.sv
tb/pfp_result_checker.sv
tb/tb_top.sv
